[sv/touch_contact_slot_tracker_unit_defines.svh]
// Assertion helpers used by the checker file.
`ifndef TOUCH_CONTACT_SLOT_TRACKER_UNIT_DEFINES_SVH
`define TOUCH_CONTACT_SLOT_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define TCST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcst check failed");

// Next-cycle implication, reset-qualified.
`define TCST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcst check failed");

`endif

[sv/tcst_pkg.sv]
package tcst_pkg;

	localparam int CONTACTS = 10;
	localparam int IDX_W    = (CONTACTS > 1) ? $clog2(CONTACTS) : 1;
	localparam int COORD_W  = 16;
	localparam int SLOT_W   = 4;
	localparam int OP_W     = 2;
	localparam int ST_W     = 3;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [OP_W-1:0] {
		OP_TOUCH   = 2'd0,
		OP_UNTOUCH = 2'd1,
		OP_MOVE    = 2'd2,
		OP_UNKNOWN = 2'd3
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_BAD_SLOT = 3'd1,
		ST_UNKNOWN  = 3'd2,
		ST_FULL     = 3'd3,
		ST_INACTIVE = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MAX = 1'b0,
		REG_Y_MAX = 1'b1
	} cfg_reg_t;

	// table write port
	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   idx;
		logic               active;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} slot_wr_t;

	// table read data at the addressed slot
	typedef struct packed {
		logic               active;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} slot_rd_t;

	// lowest free slot
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} slot_free_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic               active;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} result_t;

	// negative -> default, then cap
	function automatic logic [COORD_W-1:0] clamp_coord(
		input logic signed [COORD_W-1:0] req,
		input logic [COORD_W-1:0]        dflt,
		input logic [COORD_W-1:0]        cap
	);
		logic [COORD_W-1:0] v;
		v = req[COORD_W-1] ? dflt : COORD_W'(req);
		return (v > cap) ? cap : v;
	endfunction

endpackage

[sv/tcst_slot_table.sv]
module tcst_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcst_pkg::slot_wr_t          wr,
	input  logic [tcst_pkg::IDX_W-1:0]  rd_idx,
	output tcst_pkg::slot_rd_t          rd,
	output tcst_pkg::slot_free_t        free_slot
);
	import tcst_pkg::*;

	logic               active_q [CONTACTS];
	logic [COORD_W-1:0] x_q      [CONTACTS];
	logic [COORD_W-1:0] y_q      [CONTACTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CONTACTS; i++) begin
				active_q[i] <= 1'b0;
				x_q[i]      <= '0;
				y_q[i]      <= '0;
			end
		end else if (wr.we) begin
			active_q[wr.idx] <= wr.active;
			x_q[wr.idx]      <= wr.x;
			y_q[wr.idx]      <= wr.y;
		end
	end

	assign rd.active = active_q[rd_idx];
	assign rd.x      = x_q[rd_idx];
	assign rd.y      = y_q[rd_idx];

	// priority encoder, lowest index wins
	always_comb begin
		free_slot.found = 1'b0;
		free_slot.idx   = '0;
		for (int i = CONTACTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_slot.found = 1'b1;
				free_slot.idx   = IDX_W'(i);
			end
		end
	end

endmodule

[sv/tcst_cmd_exec.sv]
module tcst_cmd_exec (
	input  logic                               valid,
	input  tcst_pkg::opcode_t                  opcode,
	input  logic [tcst_pkg::SLOT_W-1:0]        slot_id,
	input  logic signed [tcst_pkg::COORD_W-1:0] x_coord,
	input  logic signed [tcst_pkg::COORD_W-1:0] y_coord,
	input  logic [tcst_pkg::COORD_W-1:0]       x_max,
	input  logic [tcst_pkg::COORD_W-1:0]       y_max,
	input  tcst_pkg::slot_rd_t                 rd,
	input  tcst_pkg::slot_free_t               free_slot,
	output logic [tcst_pkg::IDX_W-1:0]         rd_idx,
	output tcst_pkg::slot_wr_t                 wr,
	output tcst_pkg::result_t                  res
);
	import tcst_pkg::*;

	logic bad_slot;

	assign bad_slot = ({1'b0, slot_id} >= (SLOT_W + 1)'(CONTACTS));
	assign rd_idx   = bad_slot ? '0 : IDX_W'(slot_id);

	always_comb begin
		wr        = '0;
		res       = '0;
		res.status = ST_OK;
		unique case (opcode)
			OP_TOUCH: begin
				if (!free_slot.found) begin
					res.status = ST_FULL;
				end else begin
					wr.we     = valid;
					wr.idx    = free_slot.idx;
					wr.active = 1'b1;
					wr.x      = clamp_coord(x_coord, '0, x_max);
					wr.y      = clamp_coord(y_coord, '0, y_max);
				end
			end
			OP_UNTOUCH, OP_MOVE: begin
				priority if (bad_slot) begin
					res.status = ST_BAD_SLOT;
				end else if (!rd.active) begin
					res.status = ST_INACTIVE;
				end else begin
					wr.we  = valid;
					wr.idx = rd_idx;
					if (opcode == OP_MOVE) begin
						wr.active = 1'b1;
						wr.x      = clamp_coord(x_coord, rd.x, x_max);
						wr.y      = clamp_coord(y_coord, rd.y, y_max);
					end
				end
			end
			OP_UNKNOWN: res.status = ST_UNKNOWN;
			default:    res.status = ST_UNKNOWN;
		endcase
		// on success the report is exactly what gets written back
		if (res.status == ST_OK) begin
			res.slot   = SLOT_W'(wr.idx);
			res.active = wr.active;
			res.x      = wr.x;
			res.y      = wr.y;
		end
	end

endmodule

[sv/touch_contact_slot_tracker_unit.sv]
// A transferred command is captured in the stage-1 command register; its result is
// registered in the stage-2 result register and shown with done high.
// Throughput: one command per cycle; busy stays low, back-to-back commands see
// the table as updated by the command before them.
// Reset (arst_n low, asynchronous): slot table cleared, x_max/y_max = 4095,
// pipeline empty. The receiver cannot stall; each result is shown for one cycle.
module touch_contact_slot_tracker_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic [tcst_pkg::OP_W-1:0]            opcode,
	input  logic [tcst_pkg::SLOT_W-1:0]          slot_id,
	input  logic signed [tcst_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [tcst_pkg::COORD_W-1:0]  y_coord,
	// result channel
	output logic                                 done,
	output logic [tcst_pkg::ST_W-1:0]            status,
	output logic [tcst_pkg::SLOT_W-1:0]          report_slot,
	output logic                                 report_active,
	output logic [tcst_pkg::COORD_W-1:0]         report_x,
	output logic [tcst_pkg::COORD_W-1:0]         report_y,
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [tcst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcst_pkg::CFG_W-1:0]           cfg_wdata
);
	import tcst_pkg::*;

	// Config registers: x/y caps
	logic [COORD_W-1:0] x_max_q;
	logic [COORD_W-1:0] y_max_q;

	// Stage 1: command register
	logic                      valid_s1;
	opcode_t                   op_s1;
	logic [SLOT_W-1:0]         sid_s1;
	logic signed [COORD_W-1:0] x_s1;
	logic signed [COORD_W-1:0] y_s1;

	// Stage 2: result register
	logic    done_q;
	result_t res_q;

	// Combinational datapath between the two
	logic [IDX_W-1:0] rd_idx;
	slot_rd_t         rd;
	slot_free_t       free_slot;
	slot_wr_t         wr;
	result_t          res;

	// Never back-pressures: a new command can land every cycle.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_max_q <= COORD_W'(4095);
			y_max_q <= COORD_W'(4095);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_X_MAX: x_max_q <= cfg_wdata;
				REG_Y_MAX: y_max_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// Command capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1  <= opcode_t'(opcode);
			sid_s1 <= slot_id;
			x_s1   <= x_coord;
			y_s1   <= y_coord;
		end
	end

	tcst_slot_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_idx    (rd_idx),
		.rd        (rd),
		.free_slot (free_slot)
	);

	// Decode, clamp, build the table write and the report. The table write
	// lands on the same edge that captures the next command, so that command
	// already sees the updated slots.
	tcst_cmd_exec u_exec (
		.valid     (valid_s1),
		.opcode    (op_s1),
		.slot_id   (sid_s1),
		.x_coord   (x_s1),
		.y_coord   (y_s1),
		.x_max     (x_max_q),
		.y_max     (y_max_q),
		.rd        (rd),
		.free_slot (free_slot),
		.rd_idx    (rd_idx),
		.wr        (wr),
		.res       (res)
	);

	// Result register: one-cycle done strobe per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= res;
		end
	end

	assign done          = done_q;
	assign status        = res_q.status;
	assign report_slot   = res_q.slot;
	assign report_active = res_q.active;
	assign report_x      = res_q.x;
	assign report_y      = res_q.y;

endmodule

[sv/tcst_checker.sv]
`include "touch_contact_slot_tracker_unit_defines.svh"

module tcst_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic [tcst_pkg::ST_W-1:0]            status,
	input logic [tcst_pkg::SLOT_W-1:0]          report_slot,
	input logic                                 report_active,
	input logic [tcst_pkg::COORD_W-1:0]         report_x,
	input logic [tcst_pkg::COORD_W-1:0]         report_y
);
	import tcst_pkg::*;

	logic acc;
	logic err;
	logic rpt_zero;
	logic xy_zero;
	logic slot_ok;

	assign acc      = start && !busy;
	assign err      = (status != ST_OK);
	assign xy_zero  = (report_x == '0) && (report_y == '0);
	assign rpt_zero = (report_slot == '0) && !report_active && xy_zero;
	assign slot_ok  = (report_slot < SLOT_W'(CONTACTS));

	// every transfer in gives exactly one result, through the command and result registers
	`TCST_ASSERT_NEXT(a_result_follows, clk, arst_n, acc, ##1 done)
	`TCST_ASSERT_NOW(a_no_spurious_result, clk, arst_n, done, $past(acc, 2))
	// error results carry an all-zero report
	`TCST_ASSERT_NOW(a_err_report_zero, clk, arst_n, done && err, rpt_zero)
	// a released contact reports no position; slot stays in range
	`TCST_ASSERT_NOW(a_release_zero, clk, arst_n, done && !err && !report_active, xy_zero && slot_ok)

endmodule

bind touch_contact_slot_tracker_unit tcst_checker u_tcst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.report_slot   (report_slot),
	.report_active (report_active),
	.report_x      (report_x),
	.report_y      (report_y)
);
